[rtl/sapcs_pkg.sv]
// Shared types and constants of the servo arm command step.
// Used by the controller, the datapath and the top level; depends on nothing.
package sapcs_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int GAIN_FRAC_BITS  = 20;

    // opcodes
    localparam logic [2:0] OP_STOP        = 3'd0;
    localparam logic [2:0] OP_ACTIVATE    = 3'd1;
    localparam logic [2:0] OP_TRACK_CAP   = 3'd2;
    localparam logic [2:0] OP_TRACK_FLOOR = 3'd3;
    localparam logic [2:0] OP_HOME        = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_WINDOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_MAX  = 3'd6;
    localparam int CFG_DATA_W = 22;

    // pulse widths in microseconds
    localparam logic [11:0] PULSE_STOP_PAN      = 12'd900;
    localparam logic [11:0] PULSE_STOP_SHOULDER = 12'd1900;
    localparam logic [11:0] PULSE_ACT_SHOULDER  = 12'd1700;
    localparam logic [11:0] PULSE_NEUTRAL       = 12'd1500;
    localparam logic [10:0] STRIKER_REST        = 11'd900;
    localparam logic [10:0] STRIKER_NEUTRAL     = 11'd1500;
    localparam logic signed [12:0] PAN_CENTRE   = 13'sd1500;
    localparam logic signed [12:0] PAN_CAP      = 13'sd1800;
    localparam logic signed [12:0] PAN_FLOOR    = 13'sd1100;
    localparam logic signed [12:0] PAN_LOW      = 13'sd500;
    localparam logic signed [12:0] PAN_HIGH     = 13'sd2500;

    // datapath widths
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 47;
    localparam int RQ_W   = ACC_W - GAIN_FRAC_BITS;
    localparam int DMAG_W = 14;
    localparam int X_W    = 24;
    localparam int Q_W    = 11;

    // drive limit and the drive-to-pulse scaling (1000 / LIM by reciprocal)
    localparam int LIM        = 180 << ANGLE_FRAC_BITS;
    localparam int PULSE_SPAN = 2000 - 1000;
    localparam int DIV_SHIFT  = 30;
    localparam int DIV_RECIP  = int'((64'd1 << DIV_SHIFT) / LIM);

    // pan scaling: 1000/180 = 50/9, divide by 9 through a reciprocal
    localparam int PAN_STEP  = 50;
    localparam int PAN_SHIFT = 17;
    localparam int PAN_RECIP = 14564;

    typedef struct packed {
        logic [19:0] gain_p;
        logic [19:0] gain_i;
        logic [19:0] gain_d;
        logic [21:0] windup_limit;
        logic [13:0] strike_window;
        logic [11:0] shoulder_min;
        logic [11:0] shoulder_max;
    } cfg_t;

    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I,
        MSEL_D,
        MSEL_R
    } msel_t;

    typedef struct packed {
        logic  capture;
        logic  calc;
        msel_t mul_sel;
        logic  acc_add;
        logic  rnd;
        logic  clamp;
        logic  qest;
        logic  corr;
        logic  commit;
    } dp_cmd_t;

    typedef struct packed {
        logic track;
    } dp_stat_t;

endpackage

[rtl/sapcs_ctrl.sv]
// Sequencer of the servo arm command step: steps the datapath through one item.
// Depends on sapcs_pkg for the command and status types.
module sapcs_ctrl import sapcs_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_RND,
        ST_CLAMP,
        ST_MUL_R,
        ST_QEST,
        ST_CORR,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MSEL_P;
        case (state_reg)
            ST_IDLE:   cmd.capture = s_tvalid;
            ST_CALC:   cmd.calc = 1'b1;
            ST_MUL_P:  cmd.mul_sel = MSEL_P;
            ST_MUL_I: begin
                cmd.mul_sel = MSEL_I;
                cmd.acc_add = 1'b1;
            end
            ST_MUL_D: begin
                cmd.mul_sel = MSEL_D;
                cmd.acc_add = 1'b1;
            end
            ST_ACC:    cmd.acc_add = 1'b1;
            ST_RND:    cmd.rnd = 1'b1;
            ST_CLAMP:  cmd.clamp = 1'b1;
            ST_MUL_R:  cmd.mul_sel = MSEL_R;
            ST_QEST:   cmd.qest = 1'b1;
            ST_CORR:   cmd.corr = 1'b1;
            ST_COMMIT: cmd.commit = out_free;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new result takes precedence over the one leaving at this edge
            if (state_reg == ST_COMMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:  if (s_tvalid) state_reg <= ST_CALC;
                ST_CALC:  state_reg <= stat.track ? ST_MUL_P : ST_COMMIT;
                ST_MUL_P: state_reg <= ST_MUL_I;
                ST_MUL_I: state_reg <= ST_MUL_D;
                ST_MUL_D: state_reg <= ST_ACC;
                ST_ACC:   state_reg <= ST_RND;
                ST_RND:   state_reg <= ST_CLAMP;
                ST_CLAMP: state_reg <= ST_MUL_R;
                ST_MUL_R: state_reg <= ST_QEST;
                ST_QEST:  state_reg <= ST_CORR;
                ST_CORR:  state_reg <= ST_COMMIT;
                ST_COMMIT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/sapcs_dp.sv]
// Datapath of the servo arm command step: PID state, shared multiplier,
// rounding, shoulder and pan arithmetic and the result register. Uses sapcs_pkg.
module sapcs_dp import sapcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [2:0]         in_opcode,
    input  logic signed [14:0] in_angle_one,
    input  logic signed [14:0] in_angle_two,
    input  logic signed [14:0] in_reported_offset,
    input  logic signed [8:0]  in_target_angle,
    output logic [11:0]        out_pan_pulse,
    output logic [11:0]        out_shoulder_pulse,
    output logic [10:0]        out_striker_pulse,
    output logic               out_strike,
    output logic               out_release_res,
    output logic [14:0]        out_drive_value
);

    // captured item
    logic [2:0]         op_reg;
    logic signed [14:0] a1_reg, a2_reg, off_reg;
    logic signed [8:0]  tgt_reg;

    // per-item working registers
    logic signed [15:0]       delta_reg;
    logic signed [16:0]       deriv_reg;
    logic signed [23:0]       sum_reg;
    logic                     strike_reg;
    logic [10:0]              pq_reg;
    logic                     tneg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     rneg_reg;
    logic [RQ_W-1:0]          rq_reg;
    logic [DMAG_W-1:0]        dmag_reg;
    logic [X_W-1:0]           x_reg;
    logic [Q_W-2:0]           qest_reg;
    logic signed [11:0]       dq_reg;

    // PID and shoulder state
    logic [11:0]        store_reg;
    logic signed [23:0] integ_reg;
    logic signed [15:0] prev_reg;

    // result register
    logic [11:0] pan_o_reg, shoulder_o_reg;
    logic [10:0] striker_o_reg;
    logic        strike_o_reg, release_o_reg;
    logic [14:0] drive_o_reg;

    assign stat.track = (op_reg == OP_TRACK_CAP) || (op_reg == OP_TRACK_FLOOR);

    // ---- first step: differences, saturated integral, pan quotient, strike test
    logic signed [15:0] delta_c;
    logic signed [16:0] deriv_c;
    logic signed [24:0] sum_wide;
    logic signed [23:0] sum_c;
    logic [14:0]        omag;
    logic [8:0]         tmag;
    logic [13:0]        py;
    logic [27:0]        pprod;

    assign delta_c  = {a2_reg[14], a2_reg} - {a1_reg[14], a1_reg};
    assign deriv_c  = {delta_c[15], delta_c} - {prev_reg[15], prev_reg};
    assign sum_wide = {integ_reg[23], integ_reg} + {{9{delta_c[15]}}, delta_c};
    always_comb begin
        if (sum_wide[24] != sum_wide[23]) begin
            sum_c = sum_wide[24] ? 24'sh800000 : 24'sh7FFFFF;
        end else begin
            sum_c = sum_wide[23:0];
        end
    end
    assign omag  = off_reg[14] ? (15'd0 - off_reg) : off_reg;
    assign tmag  = tgt_reg[8] ? (9'd0 - tgt_reg) : tgt_reg;
    assign py    = 14'(tmag) * 14'(PAN_STEP);
    assign pprod = 28'(py) * 28'(PAN_RECIP);

    // ---- shared multiplier
    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0] prod_c;

    always_comb begin
        case (cmd.mul_sel)
            MSEL_P: begin
                ma = $signed({5'b0, cfg.gain_p});
                mb = $signed({{9{delta_reg[15]}}, delta_reg});
            end
            MSEL_I: begin
                ma = $signed({5'b0, cfg.gain_i});
                mb = $signed({sum_reg[23], sum_reg});
            end
            MSEL_D: begin
                ma = $signed({5'b0, cfg.gain_d});
                mb = $signed({{8{deriv_reg[16]}}, deriv_reg});
            end
            MSEL_R: begin
                ma = MUL_W'(DIV_RECIP);
                mb = $signed({1'b0, x_reg});
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end
    assign prod_c = ma * mb;

    // ---- rounding: magnitude plus half, ties away from zero
    logic [ACC_W-1:0] amag, rsum;
    assign amag = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
    assign rsum = amag + (ACC_W'(1) << (GAIN_FRAC_BITS - 1));

    // ---- clamp to the drive limit and scale by the pulse span
    logic [DMAG_W-1:0] dmag_c;
    assign dmag_c = (rq_reg > RQ_W'(LIM)) ? DMAG_W'(LIM) : rq_reg[DMAG_W-1:0];

    // ---- correct the reciprocal quotient
    logic [X_W-1:0] rem_c;
    logic [Q_W-1:0] qfix;
    assign rem_c = x_reg - X_W'(qest_reg) * X_W'(LIM);
    assign qfix  = (rem_c >= X_W'(LIM)) ? ({1'b0, qest_reg} + Q_W'(1)) : {1'b0, qest_reg};

    // ---- shoulder update: cap to max first, then raise to min
    logic signed [13:0] ssum, smax, smin, scap;
    logic [11:0]        store_c;
    assign ssum = $signed({2'b0, store_reg}) + {{2{dq_reg[11]}}, dq_reg};
    assign smax = $signed({2'b0, cfg.shoulder_max});
    assign smin = $signed({2'b0, cfg.shoulder_min});
    assign scap = (ssum > smax) ? smax : ssum;
    assign store_c = (scap < smin) ? cfg.shoulder_min : scap[11:0];

    // ---- pan finish
    logic signed [12:0] pan_s, pan_lim, pan_c;
    always_comb begin
        pan_s = tneg_reg ? (PAN_CENTRE - $signed({2'b0, pq_reg}))
                         : (PAN_CENTRE + $signed({2'b0, pq_reg}));
        pan_lim = pan_s;
        if (op_reg == OP_TRACK_CAP && pan_s > PAN_CAP) begin
            pan_lim = PAN_CAP;
        end
        if (op_reg == OP_TRACK_FLOOR && pan_s < PAN_FLOOR) begin
            pan_lim = PAN_FLOOR;
        end
        if (pan_lim < PAN_LOW) begin
            pan_c = PAN_LOW;
        end else if (pan_lim > PAN_HIGH) begin
            pan_c = PAN_HIGH;
        end else begin
            pan_c = pan_lim;
        end
    end

    logic [23:0] smag;
    logic [14:0] drive_c;
    assign smag    = sum_reg[23] ? (24'd0 - sum_reg) : sum_reg;
    assign drive_c = rneg_reg ? (15'd0 - {1'b0, dmag_reg}) : {1'b0, dmag_reg};

    // working registers, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= prod_c;
        if (cmd.capture) begin
            op_reg  <= in_opcode;
            a1_reg  <= in_angle_one;
            a2_reg  <= in_angle_two;
            off_reg <= in_reported_offset;
            tgt_reg <= in_target_angle;
        end
        if (cmd.calc) begin
            delta_reg  <= delta_c;
            deriv_reg  <= deriv_c;
            sum_reg    <= sum_c;
            strike_reg <= (omag < {1'b0, cfg.strike_window});
            pq_reg     <= pprod[PAN_SHIFT +: 11];
            tneg_reg   <= tgt_reg[8];
            acc_reg    <= '0;
        end
        if (cmd.acc_add) begin
            acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
        end
        if (cmd.rnd) begin
            rneg_reg <= acc_reg[ACC_W-1];
            rq_reg   <= rsum[ACC_W-1:GAIN_FRAC_BITS];
        end
        if (cmd.clamp) begin
            dmag_reg <= dmag_c;
            x_reg    <= X_W'(dmag_c) * X_W'(PULSE_SPAN);
        end
        if (cmd.qest) begin
            qest_reg <= prod_reg[DIV_SHIFT +: (Q_W - 1)];
        end
        if (cmd.corr) begin
            dq_reg <= rneg_reg ? (12'd0 - 12'(qfix)) : 12'(qfix);
        end
        if (cmd.commit) begin
            case (op_reg)
                OP_STOP: begin
                    pan_o_reg      <= PULSE_STOP_PAN;
                    shoulder_o_reg <= PULSE_STOP_SHOULDER;
                    striker_o_reg  <= STRIKER_REST;
                    strike_o_reg   <= 1'b0;
                    release_o_reg  <= 1'b1;
                    drive_o_reg    <= '0;
                end
                OP_ACTIVATE: begin
                    pan_o_reg      <= PULSE_NEUTRAL;
                    shoulder_o_reg <= PULSE_ACT_SHOULDER;
                    striker_o_reg  <= STRIKER_NEUTRAL;
                    strike_o_reg   <= 1'b0;
                    release_o_reg  <= 1'b0;
                    drive_o_reg    <= '0;
                end
                OP_TRACK_CAP, OP_TRACK_FLOOR: begin
                    pan_o_reg      <= pan_c[11:0];
                    shoulder_o_reg <= store_c;
                    striker_o_reg  <= strike_reg ? STRIKER_REST : STRIKER_NEUTRAL;
                    strike_o_reg   <= strike_reg;
                    release_o_reg  <= 1'b0;
                    drive_o_reg    <= drive_c;
                end
                default: begin
                    pan_o_reg      <= PULSE_NEUTRAL;
                    shoulder_o_reg <= PULSE_NEUTRAL;
                    striker_o_reg  <= STRIKER_NEUTRAL;
                    strike_o_reg   <= 1'b0;
                    release_o_reg  <= 1'b0;
                    drive_o_reg    <= '0;
                end
            endcase
        end
    end

    // controller state: shoulder store and PID memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg <= PULSE_NEUTRAL;
            integ_reg <= '0;
            prev_reg  <= '0;
        end else if (cmd.commit) begin
            case (op_reg)
                OP_STOP:     store_reg <= PULSE_STOP_SHOULDER;
                OP_ACTIVATE: store_reg <= PULSE_ACT_SHOULDER;
                OP_TRACK_CAP, OP_TRACK_FLOOR: begin
                    store_reg <= store_c;
                    // drop the integral once it runs past the limit
                    integ_reg <= (smag > {2'b0, cfg.windup_limit}) ? 24'sd0 : sum_reg;
                    prev_reg  <= delta_reg;
                end
                default:     store_reg <= store_reg;
            endcase
        end
    end

    assign out_pan_pulse      = pan_o_reg;
    assign out_shoulder_pulse = shoulder_o_reg;
    assign out_striker_pulse  = striker_o_reg;
    assign out_strike         = strike_o_reg;
    assign out_release_res    = release_o_reg;
    assign out_drive_value    = drive_o_reg;

endmodule

[rtl/servo_arm_pid_command_step.sv]
// Servo arm command step, top level: configuration registers, stream packing,
// controller and datapath. Depends on sapcs_pkg, sapcs_ctrl and sapcs_dp.
//
// Use: each item on the s_ channel is one command (opcode in s_tuser, angles
// and target in s_tdata) and yields exactly one item on the m_ channel with
// the pan, shoulder and striker pulse widths, strike and release flags and
// the clamped PID drive value.
// Stop, activate and home go from acceptance through the calculation step
// to the result register; the two track commands also pass the steps of
// the one shared 25x25 multiplier, which forms the three PID products and
// the drive scaling in series. One item is in work at a time, so s_tready
// rises again once the result is registered: an item may be accepted while
// the previous result still waits on m_tready. When the receiver stalls, the
// finished item holds in the output register and the following item waits in
// its last step.
// The cfg_ channel writes a register (index in cfg_index) at any handshake;
// write only while the block is idle.
// Reset (aresetn low, synchronous) restores the register defaults, sets the
// stored shoulder pulse to 1500 us, clears the PID memory and empties both
// channels. No clearing pass follows.
module servo_arm_pid_command_step import sapcs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // command channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // angle_one[14:0], angle_two[29:15], reported_offset[44:30],
    // target_angle[53:45], zero fill [55:54]
    input  logic [55:0]           s_tdata,
    // opcode[2:0]
    input  logic [2:0]            s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pan_pulse[11:0], shoulder_pulse[23:12], striker_pulse[34:24], strike[35],
    // release_res[36], drive_value[51:37], zero fill [55:52]
    output logic [55:0]           m_tdata,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [11:0] pan_pulse, shoulder_pulse;
    logic [10:0] striker_pulse;
    logic        strike, release_res;
    logic [14:0] drive_value;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p        <= 20'd10486;
            cfg_reg.gain_i        <= 20'd105;
            cfg_reg.gain_d        <= 20'd5243;
            cfg_reg.windup_limit  <= 22'd640000;
            cfg_reg.strike_window <= 14'd320;
            cfg_reg.shoulder_min  <= 12'd900;
            cfg_reg.shoulder_max  <= 12'd1900;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GAIN_P:        cfg_reg.gain_p        <= cfg_data[19:0];
                CFG_GAIN_I:        cfg_reg.gain_i        <= cfg_data[19:0];
                CFG_GAIN_D:        cfg_reg.gain_d        <= cfg_data[19:0];
                CFG_WINDUP_LIMIT:  cfg_reg.windup_limit  <= cfg_data[21:0];
                CFG_STRIKE_WINDOW: cfg_reg.strike_window <= cfg_data[13:0];
                CFG_SHOULDER_MIN:  cfg_reg.shoulder_min  <= cfg_data[11:0];
                CFG_SHOULDER_MAX:  cfg_reg.shoulder_max  <= cfg_data[11:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    sapcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sapcs_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .cmd                (cmd),
        .stat               (stat),
        .in_opcode          (s_tuser),
        .in_angle_one       (s_tdata[14:0]),
        .in_angle_two       (s_tdata[29:15]),
        .in_reported_offset (s_tdata[44:30]),
        .in_target_angle    (s_tdata[53:45]),
        .out_pan_pulse      (pan_pulse),
        .out_shoulder_pulse (shoulder_pulse),
        .out_striker_pulse  (striker_pulse),
        .out_strike         (strike),
        .out_release_res    (release_res),
        .out_drive_value    (drive_value)
    );

    assign m_tdata = {4'b0, drive_value, release_res, strike, striker_pulse,
                      shoulder_pulse, pan_pulse};

endmodule
